FILE: sv/rtac_pkg.sv
// Package for the region table access checker: table sizing, codes, entry
// layout and the controller/datapath command and status structs.
// No dependencies; every other file of the block refers to it by scope.
package rtac_pkg;

  localparam int MAX_REGIONS = 16;
  localparam int IDX_W       = (MAX_REGIONS > 1) ? $clog2(MAX_REGIONS) : 1;
  localparam int CNT_W       = $clog2(MAX_REGIONS + 1);

  localparam int CMD_W       = 2;
  localparam int ADDR_W      = 32;
  localparam int PERM_W      = 2;
  localparam int STATUS_W    = 3;
  localparam int IDX_OUT_W   = 4;
  localparam int CNT_OUT_W   = 5;

  typedef logic [IDX_W-1:0]     idx_t;
  typedef logic [CNT_W-1:0]     cnt_t;
  typedef logic [IDX_OUT_W-1:0] idx_out_t;
  typedef logic [CNT_OUT_W-1:0] cnt_out_t;
  typedef logic [ADDR_W-1:0]    addr_t;
  typedef logic [PERM_W-1:0]    perm_t;

  typedef enum logic [CMD_W-1:0] {
    CMD_CLEAR    = 2'd0,
    CMD_REGISTER = 2'd1,
    CMD_READ     = 2'd2,
    CMD_WRITE    = 2'd3
  } cmd_t;

  typedef enum logic [STATUS_W-1:0] {
    STAT_OK      = 3'd0,
    STAT_FULL    = 3'd1,
    STAT_OVERLAP = 3'd2,
    STAT_OOB     = 3'd3,
    STAT_PERM    = 3'd4
  } status_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_FINISH
  } state_t;

  // One table entry; lim is base + size, wrapped to 32 bits.
  typedef struct packed {
    perm_t perm;
    addr_t lim;
    addr_t base;
  } region_t;

  typedef struct packed {
    logic load;
    logic scan;
    logic commit;
  } ctrl_cmd_t;

  typedef struct packed {
    logic done;
    logic out_busy;
  } dp_stat_t;

endpackage

FILE: sv/rtac_if.sv
// Handshake channels of the region table access checker: request and result.
// Depends on rtac_pkg for field widths.
interface rtac_in_if;
  logic                            valid;
  logic                            ready;
  logic [rtac_pkg::CMD_W-1:0]      cmd;
  logic [rtac_pkg::ADDR_W-1:0]     addr;
  logic [rtac_pkg::ADDR_W-1:0]     length;
  logic [rtac_pkg::PERM_W-1:0]     region_perm;

  modport source (output valid, cmd, addr, length, region_perm, input ready);
  modport sink (input valid, cmd, addr, length, region_perm, output ready);
endinterface

interface rtac_out_if;
  logic                            valid;
  logic                            ready;
  logic [rtac_pkg::STATUS_W-1:0]   status;
  logic [rtac_pkg::IDX_OUT_W-1:0]  region_index;
  logic [rtac_pkg::CNT_OUT_W-1:0]  region_count;

  modport source (output valid, status, region_index, region_count, input ready);
  modport sink (input valid, status, region_index, region_count, output ready);
endinterface

FILE: sv/rtac_dp.sv
// Datapath of the region table access checker: request registers, region
// memory with one registered read per scan cycle, compare stage and result register.
// Depends on rtac_pkg; driven by rtac_ctrl through ctrl_cmd_t.
module rtac_dp (
  input  logic                       clk,
  input  logic                       rst_n,
  input  rtac_pkg::ctrl_cmd_t        ctl,
  output rtac_pkg::dp_stat_t         stat,
  input  logic [rtac_pkg::CMD_W-1:0] in_cmd,
  input  rtac_pkg::addr_t            in_addr,
  input  rtac_pkg::addr_t            in_length,
  input  rtac_pkg::perm_t            in_region_perm,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic [rtac_pkg::STATUS_W-1:0] out_status,
  output rtac_pkg::idx_out_t         out_region_index,
  output rtac_pkg::cnt_out_t         out_region_count
);

  rtac_pkg::region_t   mem [rtac_pkg::MAX_REGIONS];

  rtac_pkg::cmd_t      cmd_r;
  rtac_pkg::addr_t     addr_r;
  rtac_pkg::addr_t     lim_r;
  rtac_pkg::perm_t     perm_r;
  rtac_pkg::cnt_t      count_r;
  rtac_pkg::cnt_t      count_nxt;
  rtac_pkg::cnt_t      scan_idx_r;
  logic                cmp_vld_r;
  rtac_pkg::idx_t      cmp_idx_r;
  rtac_pkg::region_t   rd_data_r;

  rtac_pkg::status_t   pend_status_r;
  rtac_pkg::status_t   pend_status_nxt;
  rtac_pkg::idx_t      pend_idx_r;
  rtac_pkg::idx_t      pend_idx_nxt;
  logic                pend_add_r;
  logic                pend_add_nxt;

  logic                out_valid_r;
  rtac_pkg::status_t   out_status_r;
  rtac_pkg::idx_out_t  out_idx_r;
  rtac_pkg::cnt_out_t  out_count_r;

  logic                issue_vld;
  logic                full;
  logic                meet;
  logic                contain;
  logic                hit;
  logic                perm_ok;

  assign issue_vld = scan_idx_r < count_r;
  assign full      = count_r >= rtac_pkg::cnt_t'(rtac_pkg::MAX_REGIONS);
  assign meet      = (rd_data_r.base < lim_r) && (addr_r < rd_data_r.lim);
  assign contain   = (addr_r >= rd_data_r.base) && (lim_r <= rd_data_r.lim);
  assign hit       = cmp_vld_r && ((cmd_r == rtac_pkg::CMD_REGISTER) ? meet : contain);
  assign perm_ok   = (cmd_r == rtac_pkg::CMD_READ) ? rd_data_r.perm[0] : rd_data_r.perm[1];

  assign stat.done = (cmd_r == rtac_pkg::CMD_CLEAR)
                  || ((cmd_r == rtac_pkg::CMD_REGISTER) && full)
                  || hit
                  || (!issue_vld && !cmp_vld_r);
  assign stat.out_busy = out_valid_r && !out_ready;

  // Resolve the transaction from the command, the table fill and the compare stage
  always_comb begin
    pend_status_nxt = rtac_pkg::STAT_OK;
    pend_idx_nxt    = '0;
    pend_add_nxt    = 1'b0;
    unique case (cmd_r)
      rtac_pkg::CMD_CLEAR: begin
        pend_status_nxt = rtac_pkg::STAT_OK;
      end
      rtac_pkg::CMD_REGISTER: begin
        if (full) begin
          pend_status_nxt = rtac_pkg::STAT_FULL;
        end else if (hit) begin
          pend_status_nxt = rtac_pkg::STAT_OVERLAP;
          pend_idx_nxt    = cmp_idx_r;
        end else begin
          pend_idx_nxt    = count_r[rtac_pkg::IDX_W-1:0];
          pend_add_nxt    = 1'b1;
        end
      end
      rtac_pkg::CMD_READ, rtac_pkg::CMD_WRITE: begin
        if (hit) begin
          pend_idx_nxt    = cmp_idx_r;
          pend_status_nxt = perm_ok ? rtac_pkg::STAT_OK : rtac_pkg::STAT_PERM;
        end else begin
          pend_status_nxt = rtac_pkg::STAT_OOB;
        end
      end
      default: begin
        pend_status_nxt = rtac_pkg::STAT_OK;
      end
    endcase
  end

  always_comb begin
    count_nxt = count_r;
    if (ctl.commit) begin
      if (cmd_r == rtac_pkg::CMD_CLEAR) begin
        count_nxt = '0;
      end else if (pend_add_r) begin
        count_nxt = count_r + rtac_pkg::cnt_t'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      cmp_vld_r   <= 1'b0;
      scan_idx_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      count_r <= count_nxt;
      if (ctl.load) begin
        scan_idx_r <= '0;
        cmp_vld_r  <= 1'b0;
      end else if (ctl.scan) begin
        if (issue_vld) begin
          scan_idx_r <= scan_idx_r + rtac_pkg::cnt_t'(1);
        end
        cmp_vld_r <= issue_vld;
      end
      if (ctl.commit) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Request, compare-stage and result payload
  always_ff @(posedge clk) begin
    if (ctl.load) begin
      cmd_r  <= rtac_pkg::cmd_t'(in_cmd);
      addr_r <= in_addr;
      lim_r  <= in_addr + in_length;
      perm_r <= in_region_perm;
    end
    if (ctl.scan) begin
      cmp_idx_r <= scan_idx_r[rtac_pkg::IDX_W-1:0];
    end
    if (ctl.scan && stat.done) begin
      pend_status_r <= pend_status_nxt;
      pend_idx_r    <= pend_idx_nxt;
      pend_add_r    <= pend_add_nxt;
    end
    if (ctl.commit) begin
      out_status_r <= pend_status_r;
      out_idx_r    <= rtac_pkg::idx_out_t'(pend_idx_r);
      out_count_r  <= rtac_pkg::cnt_out_t'(count_nxt);
    end
  end

  // Region memory: append on commit, one read per scan cycle
  always_ff @(posedge clk) begin
    if (ctl.commit && pend_add_r) begin
      mem[count_r[rtac_pkg::IDX_W-1:0]] <= '{perm: perm_r, lim: lim_r, base: addr_r};
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.scan && issue_vld) begin
      rd_data_r <= mem[scan_idx_r[rtac_pkg::IDX_W-1:0]];
    end
  end

  assign out_valid        = out_valid_r;
  assign out_status       = out_status_r;
  assign out_region_index = out_idx_r;
  assign out_region_count = out_count_r;

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= rtac_pkg::cnt_t'(rtac_pkg::MAX_REGIONS))
    else $error("region count above table size");

  a_append_grows: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.commit && pend_add_r && (cmd_r == rtac_pkg::CMD_REGISTER)
      |=> count_r == $past(count_r) + rtac_pkg::cnt_t'(1))
    else $error("append did not advance region count");

  a_append_room: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.commit && pend_add_r && (cmd_r == rtac_pkg::CMD_REGISTER) |-> !full)
    else $error("append into a full table");

  a_result_from_commit: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(ctl.commit))
    else $error("result raised without a commit");

endmodule

FILE: sv/rtac_ctrl.sv
// Controller of the region table access checker: idle, scan and finish
// sequencing of one transaction at a time.
// Depends on rtac_pkg; drives rtac_dp through ctrl_cmd_t.
module rtac_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  rtac_pkg::dp_stat_t  stat,
  output rtac_pkg::ctrl_cmd_t ctl
);

  rtac_pkg::state_t state_r;
  rtac_pkg::state_t state_nxt;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      rtac_pkg::ST_IDLE: begin
        if (in_valid) begin
          state_nxt = rtac_pkg::ST_SCAN;
        end
      end
      rtac_pkg::ST_SCAN: begin
        if (stat.done) begin
          state_nxt = rtac_pkg::ST_FINISH;
        end
      end
      rtac_pkg::ST_FINISH: begin
        // hold until the result register is free
        if (!stat.out_busy) begin
          state_nxt = rtac_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = rtac_pkg::ST_IDLE;
      end
    endcase
  end

  always_comb begin
    in_ready   = 1'b0;
    ctl.load   = 1'b0;
    ctl.scan   = 1'b0;
    ctl.commit = 1'b0;
    unique case (state_r)
      rtac_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        ctl.load = in_valid;
      end
      rtac_pkg::ST_SCAN: begin
        ctl.scan = 1'b1;
      end
      rtac_pkg::ST_FINISH: begin
        ctl.commit = !stat.out_busy;
      end
      default: begin
        in_ready = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= rtac_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  a_done_to_finish: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == rtac_pkg::ST_SCAN) && stat.done |=> state_r == rtac_pkg::ST_FINISH)
    else $error("scan completion not followed by finish");

  a_commit_free: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.commit |-> !stat.out_busy)
    else $error("commit while result register still occupied");

endmodule

FILE: sv/region_table_access_checker.sv
// Region table access checker: one transaction in flight. A clear, a register into
// a full table or a request against an empty table finishes without a scan; else the
// scan reads one region per cycle and stops at the first match or after the last one.
// A new request is accepted only once the last result has been committed to the
// result register; a held result stalls the finish state.
// Synchronous active-low reset empties the table; entries stay undefined until written.
module region_table_access_checker (
  input  logic         clk,
  input  logic         rst_n,
  rtac_in_if.sink      in_chan,
  rtac_out_if.source   out_chan
);

  rtac_pkg::ctrl_cmd_t ctl;
  rtac_pkg::dp_stat_t  stat;

  rtac_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_chan.valid),
    .in_ready (in_chan.ready),
    .stat     (stat),
    .ctl      (ctl)
  );

  rtac_dp u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .ctl              (ctl),
    .stat             (stat),
    .in_cmd           (in_chan.cmd),
    .in_addr          (in_chan.addr),
    .in_length        (in_chan.length),
    .in_region_perm   (in_chan.region_perm),
    .out_valid        (out_chan.valid),
    .out_ready        (out_chan.ready),
    .out_status       (out_chan.status),
    .out_region_index (out_chan.region_index),
    .out_region_count (out_chan.region_count)
  );

endmodule
